// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the buddy block allocator: beat payloads,
// granule header entry, datapath commands and status.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int SIZE_W    = 14;
  localparam int ADDR_W    = 16;
  localparam int ORD_W     = 5;
  localparam int HDR_BYTES = 8;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_INVAL  = 2'd1;
  localparam logic [1:0] ST_NOMEM  = 2'd2;
  localparam logic [1:0] ST_BADPTR = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_addr;
    logic              addr_given;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_addr;
    logic              result_valid;
  } out_t;

  typedef struct packed {
    logic              head;
    logic              alloc;
    logic              pad;
    logic [ORD_W-1:0]  order;
    logic [SIZE_W-1:0] size;
  } gran_t;

  localparam int GRAN_W = $bits(gran_t);

  typedef enum logic [1:0] {
    ACT_INVAL,
    ACT_ALLOC,
    ACT_FREE,
    ACT_REALLOC
  } act_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_CHK_RD,
    DP_CHK_EVAL,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_PICK,
    DP_SPLIT,
    DP_MARK,
    DP_FREE_INIT,
    DP_FREE_RD,
    DP_MERGE,
    DP_FREE_FIN,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic clr_last;
    logic chk_ok;
    logic grow;
    logic chk_grow;
    logic scan_done;
    logic found;
    logic heap_full;
    logic split_more;
    logic free_top;
    logic merge_ok;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: clearing sweep, request decode, header scan,
// splitting, buddy merging and result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_CHK_RD,
    S_CHK_EVAL,
    S_SCAN_INIT,
    S_SCAN,
    S_PICK,
    S_SPLIT,
    S_FREE_INIT,
    S_FREE_RD,
    S_FREE_EVAL,
    S_FREE_FIN,
    S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  always_comb begin
    cmd.op    = DP_NOP;
    cmd.st    = st_r;
    state_nxt = state_r;
    st_nxt    = st_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          ACT_INVAL: begin
            st_nxt    = ST_INVAL;
            state_nxt = S_EMIT;
          end
          ACT_ALLOC:   state_nxt = S_SCAN_INIT;
          ACT_FREE:    state_nxt = S_CHK_RD;
          ACT_REALLOC: state_nxt = S_CHK_RD;
        endcase
      end
      S_CHK_RD: begin
        cmd.op    = DP_CHK_RD;
        state_nxt = S_CHK_EVAL;
      end
      S_CHK_EVAL: begin
        cmd.op = DP_CHK_EVAL;
        priority if (!stat.chk_ok) begin
          st_nxt    = ST_BADPTR;
          state_nxt = S_EMIT;
        end else if (stat.act == ACT_FREE) begin
          state_nxt = S_FREE_INIT;
        end else if (stat.chk_grow) begin
          state_nxt = S_SCAN_INIT;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.op    = DP_SCAN_INIT;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (stat.scan_done) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.found || !stat.heap_full) begin
          cmd.op    = DP_PICK;
          state_nxt = S_SPLIT;
        end else begin
          st_nxt    = ST_NOMEM;
          state_nxt = S_EMIT;
        end
      end
      S_SPLIT: begin
        if (stat.split_more) begin
          cmd.op = DP_SPLIT;
        end else begin
          cmd.op = DP_MARK;
          if (stat.act == ACT_REALLOC && stat.grow) begin
            state_nxt = S_FREE_INIT;
          end else begin
            st_nxt    = ST_OK;
            state_nxt = S_EMIT;
          end
        end
      end
      S_FREE_INIT: begin
        cmd.op    = DP_FREE_INIT;
        state_nxt = S_FREE_RD;
      end
      S_FREE_RD: begin
        if (stat.free_top) begin
          state_nxt = S_FREE_FIN;
        end else begin
          cmd.op    = DP_FREE_RD;
          state_nxt = S_FREE_EVAL;
        end
      end
      S_FREE_EVAL: begin
        if (stat.merge_ok) begin
          cmd.op    = DP_MERGE;
          state_nxt = S_FREE_RD;
        end else begin
          state_nxt = S_FREE_FIN;
        end
      end
      S_FREE_FIN: begin
        cmd.op    = DP_FREE_FIN;
        st_nxt    = ST_OK;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: granule header store, request registers, scan tracker,
// split and merge address logic, pointer check and result register.
// ----------------------------------------------------------------------------
module bba_dp
  import bba_pkg::*;
#(
  parameter int MIN_ORDER   = 5,
  parameter int MAX_ORDER   = 15,
  parameter int HEAP_BLOCKS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  in_t      in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  localparam int TOP      = MAX_ORDER - 1;
  localparam int GSH      = TOP - MIN_ORDER;
  localparam int GRANULES = HEAP_BLOCKS << GSH;
  localparam int AW       = (GRANULES > 1) ? $clog2(GRANULES) : 1;
  localparam int LW       = AW + 1;
  localparam int CW       = $clog2(HEAP_BLOCKS + 1);
  localparam logic [ORD_W-1:0] MIN_O = ORD_W'(MIN_ORDER);
  localparam logic [ORD_W-1:0] TOP_O = ORD_W'(TOP);
  localparam logic [31:0] MAX_PAYLOAD = (32'd1 << TOP) - 32'(HDR_BYTES);

  function automatic logic [ORD_W-1:0] fit_order(input logic [SIZE_W-1:0] sz);
    logic [31:0]      need;
    logic [ORD_W-1:0] r;
    need = 32'(sz) + 32'(HDR_BYTES);
    r    = TOP_O;
    for (int o = TOP - 1; o >= MIN_ORDER; o--) begin
      if (need <= (32'd1 << o)) r = ORD_W'(o);
    end
    return r;
  endfunction

  // request registers
  act_t              act_r;
  logic [SIZE_W-1:0] size_r;
  logic [ORD_W-1:0]  o_r;
  logic [AW-1:0]     pg_r;
  logic              pre_ok_r;
  logic [ORD_W-1:0]  old_ord_r;
  logic              grow_r;
  // allocation
  logic [AW-1:0]     g_r;
  logic [ORD_W-1:0]  k_r;
  logic [CW-1:0]     blocks_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [LW-1:0]     cnt_r;
  logic              pend_r;
  logic [AW-1:0]     scan_addr_r;
  logic              found_r;
  logic [ORD_W-1:0]  best_k_r;
  logic [AW-1:0]     best_g_r;
  // free
  logic [AW-1:0]     fg_r;
  logic [ORD_W-1:0]  fo_r;
  // result
  logic [ADDR_W-1:0] res_r;
  logic              out_valid_r;
  out_t              out_r;

  logic [LW-1:0]     lim;
  gran_t             rdat;
  logic [GRAN_W-1:0] rd_bits;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  gran_t             wr_data;

  // decode of the incoming beat
  act_t              in_act;
  logic [ADDR_W-1:0] in_hdr;
  logic              in_pre_ok;

  // pointer check on read data
  logic [31:0] chk_bs, chk_need;
  logic        chk_ok;

  logic [AW-1:0] buddy, merge_lo, merge_hi, split_up;
  logic          scan_hit;
  logic          pad_nxt;
  logic [ADDR_W-1:0] emit_addr;

  assign lim  = LW'(blocks_r) << GSH;
  assign rdat = gran_t'(rd_bits);

  always_comb begin
    in_act = ACT_INVAL;
    unique case (in_data.req_type)
      REQ_ALLOC: begin
        if (in_data.request_size != '0 && 32'(in_data.request_size) <= MAX_PAYLOAD)
          in_act = ACT_ALLOC;
      end
      REQ_FREE: in_act = ACT_FREE;
      REQ_REALLOC: begin
        priority if (!in_data.addr_given && in_data.request_size == '0) in_act = ACT_INVAL;
        else if (in_data.request_size == '0) in_act = ACT_FREE;
        else if (32'(in_data.request_size) > MAX_PAYLOAD) in_act = ACT_INVAL;
        else if (!in_data.addr_given) in_act = ACT_ALLOC;
        else in_act = ACT_REALLOC;
      end
      default: in_act = ACT_INVAL;
    endcase
  end

  assign in_hdr    = in_data.block_addr - ADDR_W'(HDR_BYTES);
  assign in_pre_ok = in_data.addr_given && (in_data.block_addr >= ADDR_W'(HDR_BYTES))
                     && (in_hdr[MIN_ORDER-1:0] == '0)
                     && (32'(in_hdr >> MIN_ORDER) < 32'(lim));

  always_comb begin
    chk_bs   = 32'd1 << rdat.order;
    chk_need = 32'(rdat.size) + 32'(HDR_BYTES);
    chk_ok   = pre_ok_r && rdat.head && rdat.alloc
               && rdat.order >= MIN_O && rdat.order <= TOP_O
               && 32'(rdat.size) <= chk_bs
               && (rdat.pad ? (chk_need != chk_bs) : (chk_need == chk_bs))
               && (fit_order(rdat.size) == rdat.order);
  end

  assign buddy    = fg_r ^ (AW'(1) << (fo_r - MIN_O));
  assign merge_lo = (buddy < fg_r) ? buddy : fg_r;
  assign merge_hi = (buddy < fg_r) ? fg_r : buddy;
  assign split_up = g_r + (AW'(1) << (k_r - MIN_O - ORD_W'(1)));
  assign pad_nxt  = (32'(size_r) + 32'(HDR_BYTES)) < (32'd1 << o_r);
  assign scan_hit = pend_r && rdat.head && !rdat.alloc && rdat.order >= o_r
                    && rdat.order <= TOP_O && (!found_r || rdat.order < best_k_r);
  assign emit_addr = (cmd.st == ST_OK) ? res_r : '0;

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = g_r;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = cnt_r[AW-1:0];
    unique case (cmd.op)
      DP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
      end
      DP_CHK_RD: begin
        rd_en   = 1'b1;
        rd_addr = pg_r;
      end
      DP_SCAN: begin
        rd_en = (cnt_r < lim);
      end
      DP_SPLIT: begin
        wr_en         = 1'b1;
        wr_addr       = split_up;
        wr_data.head  = 1'b1;
        wr_data.order = k_r - ORD_W'(1);
      end
      DP_MARK: begin
        wr_en         = 1'b1;
        wr_addr       = g_r;
        wr_data.head  = 1'b1;
        wr_data.alloc = 1'b1;
        wr_data.pad   = pad_nxt;
        wr_data.order = o_r;
        wr_data.size  = size_r;
      end
      DP_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = buddy;
      end
      DP_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = merge_hi;
      end
      DP_FREE_FIN: begin
        wr_en         = 1'b1;
        wr_addr       = fg_r;
        wr_data.head  = 1'b1;
        wr_data.order = fo_r;
      end
      default: ;
    endcase
  end

  bba_ram #(
    .WIDTH (GRAN_W),
    .DEPTH (GRANULES)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r    <= '0;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == DP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        DP_CLR: clr_cnt_r <= clr_cnt_r + AW'(1);
        DP_SCAN_INIT: begin
          pend_r  <= 1'b0;
          found_r <= 1'b0;
        end
        DP_SCAN: begin
          pend_r <= (cnt_r < lim);
          if (scan_hit) found_r <= 1'b1;
        end
        DP_PICK: begin
          if (!found_r) blocks_r <= blocks_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        act_r    <= in_act;
        size_r   <= in_data.request_size;
        o_r      <= fit_order(in_data.request_size);
        pg_r     <= AW'(in_hdr >> MIN_ORDER);
        pre_ok_r <= in_pre_ok;
        grow_r   <= 1'b0;
        res_r    <= '0;
      end
      DP_CHK_EVAL: begin
        old_ord_r <= rdat.order;
        grow_r    <= o_r > rdat.order;
        g_r       <= pg_r;
        k_r       <= rdat.order;
      end
      DP_SCAN_INIT: cnt_r <= '0;
      DP_SCAN: begin
        if (cnt_r < lim) begin
          cnt_r       <= cnt_r + LW'(1);
          scan_addr_r <= cnt_r[AW-1:0];
        end
        if (scan_hit) begin
          best_k_r <= rdat.order;
          best_g_r <= scan_addr_r;
        end
      end
      DP_PICK: begin
        if (found_r) begin
          g_r <= best_g_r;
          k_r <= best_k_r;
        end else begin
          // fresh top-order block at the end of the heap
          g_r <= lim[AW-1:0];
          k_r <= TOP_O;
        end
      end
      DP_SPLIT: k_r <= k_r - ORD_W'(1);
      DP_MARK:  res_r <= ADDR_W'((32'(g_r) << MIN_ORDER) + 32'(HDR_BYTES));
      DP_FREE_INIT: begin
        fg_r <= pg_r;
        fo_r <= old_ord_r;
      end
      DP_MERGE: begin
        fg_r <= merge_lo;
        fo_r <= fo_r + ORD_W'(1);
      end
      DP_EMIT: begin
        out_r.status       <= cmd.st;
        out_r.result_addr  <= emit_addr;
        out_r.result_valid <= (emit_addr != '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.act        = act_r;
    stat.clr_last   = (clr_cnt_r == AW'(GRANULES - 1));
    stat.chk_ok     = chk_ok;
    stat.grow       = grow_r;
    stat.chk_grow   = (o_r > rdat.order);
    stat.scan_done  = (cnt_r >= lim) && !pend_r;
    stat.found      = found_r;
    stat.heap_full  = (32'(blocks_r) >= HEAP_BLOCKS);
    stat.split_more = (k_r > o_r);
    stat.free_top   = (fo_r >= TOP_O);
    stat.merge_ok   = rdat.head && !rdat.alloc && (rdat.order == fo_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_blocks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(blocks_r) <= HEAP_BLOCKS)
    else $error("heap grew beyond its block bound");

  a_scan_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_SCAN && pend_r) |-> (LW'(scan_addr_r) < lim))
    else $error("scan read outside the grown heap");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_EMIT) |-> (!out_valid_r || !out_stall))
    else $error("result written over a beat still waiting");

  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_SPLIT) |-> (k_r > o_r && k_r <= TOP_O))
    else $error("split below the fitting order");

endmodule

// ===== rtl/buddy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Power-of-two buddy allocator keeping header metadata for a heap that grows
// one top-order block at a time.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  in_data  (in_t)
//   out_     out  out_valid / out_stall out_data (out_t)
//
// after reset a clearing sweep over all GRANULES entries (2048 by default) runs
// through the header store with in_stall high.
// alloc reads the lim granules of the grown heap, one read per granule
// through the single store read port, then does one write per split; a
// growing realloc adds the pointer check and the free.
// free of a top-order block skips the merge loop, else each buddy merge adds
// one header read and one write; shrink writes one header per split.
// one request is worked at a time; the next beat is taken while the result
// waits in the output register.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MIN_ORDER   = 5,
  parameter int MAX_ORDER   = 15,
  parameter int HEAP_BLOCKS = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .MIN_ORDER   (MIN_ORDER),
    .MAX_ORDER   (MAX_ORDER),
    .HEAP_BLOCKS (HEAP_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
